FILE: src/assert_macros.svh
// Assertion macros shared by the texture slot cache RTL.
// Every macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property wrapper with the reset qualifier of the design.
`define TSC_PROP(expr) @(posedge clk) disable iff (!arst_n) (expr)

// Labeled concurrent assertion that reports through $error.
`define TSC_ASSERT(label, expr, msg) \
	label: assert property (`TSC_PROP(expr)) else $error(msg);

`endif

FILE: src/tsc_pkg.sv
// Shared types and constants of the texture slot cache replacement policy.
// No dependencies; used by the interfaces, the slot cell and the top level.
`timescale 1ns / 1ps

package tsc_pkg;

	// Fixed field widths of the transactions and the slot state.
	localparam int TAG_W      = 32;
	localparam int ADDR_W     = 32;
	localparam int HIT_W      = 16;
	localparam int ACTIVE_W   = 5;
	localparam int CMD_W      = 2;
	localparam int STATUS_W   = 3;
	localparam int SLOT_OUT_W = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	// Slot count range; index and count widths cover the largest slot count.
	localparam int MAX_SLOTS_LIMIT = 256;
	localparam int IDX_W           = $clog2(MAX_SLOTS_LIMIT);
	localparam int CNT_W           = $clog2(MAX_SLOTS_LIMIT + 1);

	localparam int DEF_MAX_SLOTS  = 16;
	localparam int DEF_SLOT_BYTES = 256 * 256 * 2;

	localparam logic [HIT_W-1:0] HIT_MAX = '1;

	localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(16);
	localparam logic [ADDR_W-1:0]   BASE_RESET   = '0;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SLOTS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_BASE = 1'b1;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BEGIN  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_END    = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_HIT   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FREE  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EVICT = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DELAY = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FRAME = 3'd4;

	// Update broadcast from the controller to every slot cell.
	typedef enum logic [2:0] {
		UPD_NONE,
		UPD_HIT,
		UPD_CLAIM,
		UPD_BEGIN,
		UPD_END
	} upd_op_t;

	typedef struct packed {
		upd_op_t            op;
		logic [IDX_W-1:0]   idx;
		logic [TAG_W-1:0]   tag;
	} upd_t;

	// Search token handed from cell to cell during a lookup.
	typedef struct packed {
		logic               hit;
		logic [IDX_W-1:0]   hit_idx;
		logic               free;
		logic [IDX_W-1:0]   free_idx;
		logic               any;
		logic [IDX_W-1:0]   min_idx;
		logic [HIT_W-1:0]   min_cnt;
	} tok_t;

endpackage

FILE: src/tsc_if.sv
// Valid/ready channel interfaces for lookup requests and lookup results.
// Depends on tsc_pkg for the field widths.
`timescale 1ns / 1ps

interface tsc_req_if
	import tsc_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [TAG_W-1:0]    texture_tag;
	logic                force_load;

	modport source (output valid, output command, output texture_tag, output force_load,
		input ready);
	modport sink (input valid, input command, input texture_tag, input force_load,
		output ready);
endinterface

interface tsc_rsp_if
	import tsc_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [SLOT_OUT_W-1:0] slot_index;
	logic [ADDR_W-1:0]     texture_handle;

	modport source (output valid, output status, output slot_index, output texture_handle,
		input ready);
	modport sink (input valid, input status, input slot_index, input texture_handle,
		output ready);
endinterface

FILE: src/tsc_cell.sv
// One texture slot: holds its tag, flags and hit count, and refines the
// search token passed along the chain. Depends on tsc_pkg.
`timescale 1ns / 1ps

module tsc_cell
	import tsc_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] live_n,
	input  logic [TAG_W-1:0] req_tag,
	input  upd_t             upd,
	input  logic             in_vld,
	input  tok_t             in_tok,
	output logic             out_vld,
	output tok_t             out_tok
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [TAG_W-1:0] tag_q;
	logic             valid_q;
	logic             used_q;
	logic             flush_q;
	logic [HIT_W-1:0] cnt_q;
	logic             active;
	logic             selected;
	tok_t             nxt_tok;
	tok_t             tok_q;
	logic             vld_q;

	assign active   = CNT_W'(IDX) < live_n;
	assign selected = upd.idx == MY_IDX;

	// First matching slot wins the hit; the last flushable one is the free
	// slot; the minimum hit count keeps the lowest index on a tie.
	always_comb begin
		nxt_tok = in_tok;
		if (active) begin
			if (valid_q && (tag_q == req_tag) && !in_tok.hit) begin
				nxt_tok.hit     = 1'b1;
				nxt_tok.hit_idx = MY_IDX;
			end
			if (flush_q) begin
				nxt_tok.free     = 1'b1;
				nxt_tok.free_idx = MY_IDX;
			end
			if (!in_tok.any || (cnt_q < in_tok.min_cnt)) begin
				nxt_tok.any     = 1'b1;
				nxt_tok.min_idx = MY_IDX;
				nxt_tok.min_cnt = cnt_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q   <= '0;
			valid_q <= 1'b0;
			used_q  <= 1'b0;
			flush_q <= 1'b1;
			cnt_q   <= '0;
			vld_q   <= 1'b0;
		end else begin
			vld_q <= in_vld;
			case (upd.op)
				UPD_HIT: begin
					if (selected) begin
						flush_q <= 1'b0;
						used_q  <= 1'b1;
						if (cnt_q != HIT_MAX) begin
							cnt_q <= cnt_q + HIT_W'(1);
						end
					end
				end
				UPD_CLAIM: begin
					if (selected) begin
						tag_q   <= upd.tag;
						valid_q <= 1'b1;
						used_q  <= 1'b1;
						flush_q <= 1'b0;
						cnt_q   <= HIT_W'(1);
					end
				end
				UPD_BEGIN: begin
					if (active) begin
						used_q <= 1'b0;
					end
				end
				UPD_END: begin
					if (active && !used_q) begin
						flush_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_vld) begin
			tok_q <= nxt_tok;
		end
	end

	assign out_vld = vld_q;
	assign out_tok = tok_q;

endmodule

FILE: src/texture_slot_cache_policy.sv
// Texture slot cache replacement policy: controller, output register and the slot cell chain.
// Depends on tsc_pkg, tsc_if, tsc_cell and assert_macros.svh.
// A lookup result is loaded once the search token has walked the whole cell chain; a frame command
// skips the search. Decide waits while an earlier result has not been taken.
// A new transaction is taken only in idle, so only one transaction is in work at a time.
// Reset: every slot invalid, unused, flushable, hit count zero; 16 active slots, base zero.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module texture_slot_cache_policy
	import tsc_pkg::*;
#(
	parameter int MAX_SLOTS  = DEF_MAX_SLOTS,
	parameter int SLOT_BYTES = DEF_SLOT_BYTES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	tsc_req_if.sink               lookup,
	tsc_rsp_if.source             result
);

	// The controller steps through three states. In idle it takes a request
	// transaction. A lookup launches a search token into the first cell; the
	// token moves one cell per cycle and each active cell folds in its tag
	// match, its flushable mark and its hit count. When the token leaves the
	// last cell, the decide state picks the outcome, broadcasts the state
	// update to all cells and loads the result register in the same cycle.
	// Frame commands skip the search and go straight to decide.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_DECIDE
	} state_t;

	state_t               state_q;
	logic                 start_q;
	logic [CMD_W-1:0]     req_cmd_q;
	logic [TAG_W-1:0]     req_tag_q;
	logic                 req_force_q;
	logic [ACTIVE_W-1:0]  active_q;
	logic [ADDR_W-1:0]    base_q;
	logic                 out_vld_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [SLOT_OUT_W-1:0] out_slot_q;
	logic [ADDR_W-1:0]    out_handle_q;

	logic [CNT_W-1:0]     live_n;
	logic [MAX_SLOTS:0]   vld_w;
	tok_t                 tok_w [MAX_SLOTS+1];
	tok_t                 tail;
	upd_t                 dec_upd;
	upd_t                 upd;
	logic [STATUS_W-1:0]  dec_status;
	logic                 has_handle;
	logic                 out_free;
	logic [ADDR_W-1:0]    dec_handle;

	// Configuration registers: the user writes them only while the block is idle; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
			base_q   <= BASE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACTIVE_SLOTS: active_q <= cfg_data[ACTIVE_W-1:0];
				REG_TEXTURE_BASE: base_q   <= cfg_data[ADDR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// A programmed slot count above the number of cells acts as all cells.
	assign live_n = (CNT_W'(active_q) > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
		: CNT_W'(active_q);

	// The chain: cell i takes the token from cell i-1 and hands its own on.
	assign vld_w[0] = start_q;
	assign tok_w[0] = '0;

	for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
		tsc_cell #(
			.IDX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.live_n  (live_n),
			.req_tag (req_tag_q),
			.upd     (upd),
			.in_vld  (vld_w[i]),
			.in_tok  (tok_w[i]),
			.out_vld (vld_w[i+1]),
			.out_tok (tok_w[i+1])
		);
	end

	assign tail = tok_w[MAX_SLOTS];

	// Outcome of the transaction in work. A hit wins over a free slot, a
	// free slot over eviction; eviction needs force_load and at least one
	// active slot, otherwise the answer is delay and no slot changes.
	always_comb begin
		dec_status  = ST_FRAME;
		dec_upd.op  = UPD_NONE;
		dec_upd.idx = '0;
		dec_upd.tag = req_tag_q;
		case (req_cmd_q)
			CMD_BEGIN: begin
				dec_upd.op = UPD_BEGIN;
			end
			CMD_END: begin
				dec_upd.op = UPD_END;
			end
			CMD_LOOKUP: begin
				if (tail.hit) begin
					dec_status  = ST_HIT;
					dec_upd.op  = UPD_HIT;
					dec_upd.idx = tail.hit_idx;
				end else if (tail.free) begin
					dec_status  = ST_FREE;
					dec_upd.op  = UPD_CLAIM;
					dec_upd.idx = tail.free_idx;
				end else if (req_force_q && tail.any) begin
					dec_status  = ST_EVICT;
					dec_upd.op  = UPD_CLAIM;
					dec_upd.idx = tail.min_idx;
				end else begin
					dec_status = ST_DELAY;
				end
			end
			default: begin
			end
		endcase
	end

	assign has_handle = dec_status inside {ST_HIT, ST_FREE, ST_EVICT};
	assign dec_handle = base_q + (ADDR_W'(dec_upd.idx) * ADDR_W'(SLOT_BYTES));

	// The result register parts the two sides: decide waits only while an
	// earlier result has not been taken.
	assign out_free = !out_vld_q || result.ready;

	always_comb begin
		upd    = dec_upd;
		upd.op = UPD_NONE;
		if ((state_q == S_DECIDE) && out_free) begin
			upd.op = dec_upd.op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			start_q      <= 1'b0;
			out_vld_q    <= 1'b0;
			req_cmd_q    <= CMD_LOOKUP;
			req_tag_q    <= '0;
			req_force_q  <= 1'b0;
			out_status_q <= ST_FRAME;
			out_slot_q   <= '0;
			out_handle_q <= '0;
		end else begin
			// A lookup taken in idle launches the search token next cycle.
			start_q <= (state_q == S_IDLE) && lookup.valid && (lookup.command == CMD_LOOKUP);
			// A new result loads in decide; otherwise a taken result empties the register.
			if ((state_q == S_DECIDE) && out_free) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (lookup.valid) begin
						req_cmd_q   <= lookup.command;
						req_tag_q   <= lookup.texture_tag;
						req_force_q <= lookup.force_load;
						if (lookup.command == CMD_LOOKUP) begin
							state_q <= S_SEARCH;
						end else begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_SEARCH: begin
					if (vld_w[MAX_SLOTS]) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (out_free) begin
						out_status_q <= dec_status;
						out_slot_q   <= has_handle ? dec_upd.idx[SLOT_OUT_W-1:0] : '0;
						out_handle_q <= has_handle ? dec_handle : '0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign lookup.ready          = state_q == S_IDLE;
	assign result.valid          = out_vld_q;
	assign result.status         = out_status_q;
	assign result.slot_index     = out_slot_q;
	assign result.texture_handle = out_handle_q;

	// Only one search token may travel the chain at any time.
	`TSC_ASSERT(a_one_token, $onehot0(vld_w), "more than one search token in the chain")

	// The token leaves the last cell only while the controller waits for it.
	`TSC_ASSERT(a_tail_in_search, vld_w[MAX_SLOTS] |-> (state_q == S_SEARCH),
		"search token arrived outside the search state")

	// Every slot update comes with a result loaded at the same edge.
	`TSC_ASSERT(a_update_has_result, (upd.op != UPD_NONE) |=> out_vld_q,
		"slot state changed without a result")

	// Delay and frame results carry no slot and no handle.
	`TSC_ASSERT(a_no_handle, (out_vld_q && (out_status_q == ST_DELAY
		|| out_status_q == ST_FRAME)) |-> (out_slot_q == '0 && out_handle_q == '0),
		"handle given with a delay or frame result")

endmodule

FILE: test/texture_slot_cache_policy_test.sv
// Self-checking testbench for the texture slot cache replacement policy.
// Depends on tsc_pkg, the tsc_req_if / tsc_rsp_if interfaces and the top level RTL.
`timescale 1ns / 1ps

module texture_slot_cache_policy_test;
	import tsc_pkg::*;

	// Command 3 has no name in the package; the block must answer it like a frame
	// command and leave every slot alone.
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

	localparam int MODEL_SLOTS = DEF_MAX_SLOTS;
	localparam int SLOT_SIZE   = DEF_SLOT_BYTES;
	localparam int HOLD_CYCLES = 250;
	localparam int DRAIN_CYCLES = 2 * (DEF_MAX_SLOTS + 3);
	// Roughly 950 transactions are sent over the run; the limit leaves a wide
	// margin on top of the time that they take.
	localparam int RUN_LIMIT = 500000;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [SLOT_OUT_W-1:0] slot_index;
		logic [ADDR_W-1:0]     texture_handle;
	} slot_outcome_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tsc_req_if lookup_ch ();
	tsc_rsp_if result_ch ();

	texture_slot_cache_policy i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.lookup    (lookup_ch),
		.result    (result_ch)
	);

	// Shadow copy of the slot table and of the two registers. It is only
	// touched by the stimulus process, at the edge where a transaction is accepted
	// or a register write takes effect, so it can run ahead of what the block holds.
	logic [TAG_W-1:0]    held_tag   [MODEL_SLOTS];
	bit                  held_valid [MODEL_SLOTS];
	bit                  used_mark  [MODEL_SLOTS];
	bit                  flush_mark [MODEL_SLOTS];
	logic [HIT_W-1:0]    hit_total  [MODEL_SLOTS];
	logic [ACTIVE_W-1:0] cfg_active;
	logic [ADDR_W-1:0]   cfg_base;

	slot_outcome_t awaited_outcomes [$];
	logic [TAG_W-1:0] tag_pool [32];

	int mismatch_count = 0;
	int cycle_count = 0;
	int phase_items;
	bit jitter_on = 1'b1;
	int hold_ticket = 0;
	int hold_served = 0;
	int hold_left = 0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Computes the answer to one transaction and applies its effect on the
	// shadow slot table. Slots at or above the active count are left untouched.
	function automatic slot_outcome_t predict_slot_outcome(logic [CMD_W-1:0] cmd,
		logic [TAG_W-1:0] tag, logic force_ld);
		slot_outcome_t r;
		int live;
		int pick;
		bit found;
		r.status = ST_FRAME;
		r.slot_index = '0;
		r.texture_handle = '0;
		live = (cfg_active > MODEL_SLOTS) ? MODEL_SLOTS : int'(cfg_active);
		if (cmd == CMD_BEGIN) begin
			for (int i = 0; i < live; i++) used_mark[i] = 1'b0;
			return r;
		end
		if (cmd != CMD_LOOKUP) begin
			if (cmd == CMD_END)
				for (int i = 0; i < live; i++)
					if (!used_mark[i]) flush_mark[i] = 1'b1;
			return r;
		end

		// Tag search: only valid slots can match.
		found = 1'b0;
		pick = 0;
		for (int i = 0; i < live; i++) begin
			if (!found && held_valid[i] && held_tag[i] == tag) begin
				found = 1'b1;
				pick = i;
			end
		end
		if (found) begin
			flush_mark[pick] = 1'b0;
			used_mark[pick] = 1'b1;
			if (hit_total[pick] != HIT_MAX) hit_total[pick] = hit_total[pick] + 1'b1;
			r.status = ST_HIT;
		end else begin
			// Miss: the highest flushable slot wins.
			for (int i = 0; i < live; i++) begin
				if (flush_mark[i]) begin
					found = 1'b1;
					pick = i;
				end
			end
			if (found) begin
				r.status = ST_FREE;
			end else if (force_ld && live > 0) begin
				// Eviction takes the fewest hits, the lower index on a tie.
				pick = 0;
				for (int i = 1; i < live; i++)
					if (hit_total[i] < hit_total[pick]) pick = i;
				found = 1'b1;
				r.status = ST_EVICT;
			end else begin
				r.status = ST_DELAY;
				return r;
			end
			held_tag[pick] = tag;
			held_valid[pick] = 1'b1;
			used_mark[pick] = 1'b1;
			flush_mark[pick] = 1'b0;
			hit_total[pick] = HIT_W'(1);
		end
		r.slot_index = SLOT_OUT_W'(pick);
		r.texture_handle = cfg_base + ADDR_W'(pick) * ADDR_W'(SLOT_SIZE);
		return r;
	endfunction

	// Receiver: random stalls, plus one long hold-off on request.
	// The hold-off is counted here so the sender keeps offering transactions
	// and the block backs up into its request channel.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_ticket != hold_served) begin
			hold_served <= hold_ticket;
			hold_left <= HOLD_CYCLES;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= !(jitter_on && $urandom_range(99) < 9);
		end
	end

	// Result checker: each result transaction is matched against the oldest
	// prediction, field by field.
	always @(posedge clk) begin
		slot_outcome_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (awaited_outcomes.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual status %0d slot %0d handle %h",
					$time, result_ch.status, result_ch.slot_index, result_ch.texture_handle);
				mismatch_count++;
			end else begin
				want = awaited_outcomes.pop_front();
				if (result_ch.status !== want.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, want.status, result_ch.status);
					mismatch_count++;
				end
				if (result_ch.slot_index !== want.slot_index) begin
					$display("%0t: slot_index mismatch: expected %0d, actual %0d",
						$time, want.slot_index, result_ch.slot_index);
					mismatch_count++;
				end
				if (result_ch.texture_handle !== want.texture_handle) begin
					$display("%0t: texture_handle mismatch: expected %h, actual %h",
						$time, want.texture_handle, result_ch.texture_handle);
					mismatch_count++;
				end
			end
		end
	end

	// Offers one transaction and returns at the edge where it is accepted.
	// valid is left high on purpose: the next call, in the same time step,
	// either replaces the payload or lowers valid for a gap.
	task automatic send_item(logic [CMD_W-1:0] cmd, logic [TAG_W-1:0] tag, logic force_ld);
		int gap;
		if (jitter_on && $urandom_range(99) < 9) begin
			gap = $urandom_range(1, 6);
			lookup_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		lookup_ch.valid <= 1'b1;
		lookup_ch.command <= cmd;
		lookup_ch.texture_tag <= tag;
		lookup_ch.force_load <= force_ld;
		do @(posedge clk); while (!lookup_ch.ready);
		awaited_outcomes.push_back(predict_slot_outcome(cmd, tag, force_ld));
		phase_items++;
	endtask

	// Drops valid and waits until every predicted result has come back.
	task automatic settle_block();
		lookup_ch.valid <= 1'b0;
		while (awaited_outcomes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes both registers on consecutive edges. The upper bits of the slot
	// count word carry random junk, which the block must ignore.
	task automatic set_config(logic [ACTIVE_W-1:0] active, logic [ADDR_W-1:0] base);
		cfg_we <= 1'b1;
		cfg_index <= REG_ACTIVE_SLOTS;
		cfg_data <= {(CFG_DATA_W - ACTIVE_W)'($urandom), active};
		@(posedge clk);
		cfg_active = active;
		cfg_index <= REG_TEXTURE_BASE;
		cfg_data <= base;
		@(posedge clk);
		cfg_base = base;
		cfg_we <= 1'b0;
	endtask

	task automatic draw_tag_pool(int count);
		for (int i = 0; i < count; i++) tag_pool[i] = $urandom;
		tag_pool[0] = '0;
		tag_pool[1] = '1;
	endtask

	// One well-formed frame: begin, a few lookups mostly from the tag pool,
	// end. Now and then a stray command follows as noise.
	task automatic send_frame(int pool_n);
		int lookups;
		logic [TAG_W-1:0] tag;
		send_item(CMD_BEGIN, $urandom, 1'($urandom));
		lookups = $urandom_range(1, 10);
		repeat (lookups) begin
			tag = ($urandom_range(99) < 85) ? tag_pool[$urandom_range(pool_n - 1)] : $urandom;
			send_item(CMD_LOOKUP, tag, $urandom_range(99) < 60);
		end
		send_item(CMD_END, $urandom, 1'($urandom));
		if ($urandom_range(99) < 12)
			send_item(CMD_W'($urandom_range(3)), $urandom, 1'($urandom));
	endtask

	task automatic run_frame_traffic(int item_goal, int pool_n);
		phase_items = 0;
		while (phase_items < item_goal) send_frame(pool_n);
	endtask

	// After reset all slots are free and invalid: a tag of zero must miss
	// even though every stored tag is zero, and claims start at the top slot.
	task automatic test_reset_state();
		send_item(CMD_LOOKUP, '0, 1'b0);
		send_item(CMD_LOOKUP, '0, 1'b0);
		send_item(CMD_LOOKUP, '1, 1'b1);
		send_item(CMD_UNKNOWN, '1, 1'b1);
		send_item(CMD_BEGIN, '0, 1'b0);
		send_item(CMD_END, '1, 1'b1);
		send_item(CMD_LOOKUP, '1, 1'b0);
		settle_block();
	endtask

	// Two active slots, base at the top of the address space so the handle
	// wraps. Covers delay without force, eviction on a hit-count tie and on a
	// clear minimum, and reuse of freed slots after a frame boundary.
	task automatic test_eviction();
		set_config(ACTIVE_W'(2), '1);
		send_item(CMD_LOOKUP, 32'h0000_00a1, 1'b0);
		send_item(CMD_LOOKUP, 32'h0000_00b2, 1'b0);
		send_item(CMD_LOOKUP, 32'h0000_00c3, 1'b0);
		send_item(CMD_LOOKUP, 32'h0000_00c3, 1'b1);
		send_item(CMD_LOOKUP, 32'h0000_00a1, 1'b0);
		send_item(CMD_LOOKUP, 32'h0000_00d4, 1'b1);
		send_item(CMD_BEGIN, '0, 1'b0);
		send_item(CMD_END, '0, 1'b0);
		send_item(CMD_LOOKUP, 32'h0000_00e5, 1'b0);
		settle_block();
	endtask

	// With no active slots every lookup is delayed, even with force set.
	task automatic test_zero_active();
		set_config('0, 32'h8000_0000);
		send_item(CMD_LOOKUP, '1, 1'b1);
		send_item(CMD_BEGIN, '0, 1'b1);
		send_item(CMD_END, '0, 1'b1);
		send_item(CMD_LOOKUP, '0, 1'b0);
		settle_block();
	endtask

	// A slot count above the table size acts as the full table, so the
	// textures loaded into the top slots at the start hit again.
	task automatic test_over_max();
		set_config(ACTIVE_W'(31), 32'h1234_0000);
		send_item(CMD_LOOKUP, '0, 1'b0);
		send_item(CMD_LOOKUP, '1, 1'b1);
		settle_block();
	endtask

	task automatic test_random_full_table();
		set_config(ACTIVE_W'(16), $urandom);
		draw_tag_pool(24);
		run_frame_traffic(220, 24);
		settle_block();
	endtask

	task automatic test_random_partial_table();
		set_config(ACTIVE_W'($urandom_range(1, 16)), $urandom);
		draw_tag_pool(16);
		run_frame_traffic(180, 16);
		settle_block();
	endtask

	task automatic test_random_oversized_count();
		set_config(ACTIVE_W'(31), '1);
		draw_tag_pool(32);
		run_frame_traffic(150, 32);
		settle_block();
	endtask

	task automatic test_random_single_slot();
		set_config(ACTIVE_W'(1), '0);
		draw_tag_pool(4);
		run_frame_traffic(80, 4);
		settle_block();
	endtask

	task automatic test_random_no_slots();
		set_config('0, $urandom);
		draw_tag_pool(8);
		run_frame_traffic(30, 8);
		settle_block();
	endtask

	// Both sides run without idling; partway through, the receiver holds off
	// long enough for the block to fill and stall its request channel.
	task automatic test_result_backpressure();
		set_config(ACTIVE_W'(5), $urandom);
		jitter_on = 1'b0;
		draw_tag_pool(8);
		run_frame_traffic(30, 8);
		hold_ticket <= hold_ticket + 1;
		run_frame_traffic(120, 8);
		settle_block();
		jitter_on = 1'b1;
	endtask

	task automatic test_random_any_count();
		set_config(ACTIVE_W'($urandom_range(0, 31)), $urandom);
		draw_tag_pool(20);
		run_frame_traffic(90, 20);
		settle_block();
	endtask

	// Shadow state matches the documented reset: slots invalid, unused,
	// flushable, no hits; sixteen active slots and a zero base.
	initial begin
		for (int i = 0; i < MODEL_SLOTS; i++) begin
			held_tag[i] = '0;
			held_valid[i] = 1'b0;
			used_mark[i] = 1'b0;
			flush_mark[i] = 1'b1;
			hit_total[i] = '0;
		end
		cfg_active = ACTIVE_RESET;
		cfg_base = BASE_RESET;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ACTIVE_SLOTS;
		cfg_data = '0;
		lookup_ch.valid = 1'b0;
		lookup_ch.command = CMD_LOOKUP;
		lookup_ch.texture_tag = '0;
		lookup_ch.force_load = 1'b0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_eviction();
		test_zero_active();
		test_over_max();
		test_random_full_table();
		test_random_partial_table();
		test_random_oversized_count();
		test_random_single_slot();
		test_random_no_slots();
		test_result_backpressure();
		test_random_any_count();

		// Any result that shows up during the drain window is flagged by the
		// checker as unexpected.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
